@@ rtl/vector_pid_velocity_corrector_defines.svh @@
// Assertion helpers for the PID corrector
`ifndef VECTOR_PID_VELOCITY_CORRECTOR_DEFINES_SVH
`define VECTOR_PID_VELOCITY_CORRECTOR_DEFINES_SVH

`ifndef SYNTHESIS
`define VPVC_ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("vpvc invariant violated");
`define VPVC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vpvc sequence check failed");
`else
`define VPVC_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define VPVC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

@@ rtl/vpvc_pkg.sv @@
`timescale 1ns / 1ps
package vpvc_pkg;

  localparam int GAIN_W = 16;
  localparam int ERR_W  = 16;
  localparam int SUM_W  = 32;
  localparam int WIDE_W = 42;

  localparam logic [1:0] SAT_COUNT = 2'd2;

  localparam logic signed [GAIN_W-1:0] PROP_RESET  = 16'sd256;
  localparam logic signed [GAIN_W-1:0] DERIV_RESET = 16'sd0;
  localparam logic signed [GAIN_W-1:0] INTEG_RESET = 16'sd0;

  typedef enum logic [1:0] {
    CFG_PROP  = 2'd0,
    CFG_DERIV = 2'd1,
    CFG_INTEG = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] prop;
    logic signed [GAIN_W-1:0] deriv;
    logic signed [GAIN_W-1:0] integ;
  } gains_t;

  // clamp to signed 32 bits: in range when all bits above bit 30 agree
  function automatic logic signed [SUM_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    if ((&v[WIDE_W-1:SUM_W-1]) || !(|v[WIDE_W-1:SUM_W-1])) begin
      r = v[SUM_W-1:0];
    end else if (v[WIDE_W-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

@@ rtl/vpvc_axis.sv @@
`timescale 1ns / 1ps
module vpvc_axis (
  input  logic                                clk,
  input  logic                                adv,
  input  vpvc_pkg::gains_t                    gains,
  input  logic signed [vpvc_pkg::ERR_W-1:0]   err,
  input  logic signed [vpvc_pkg::ERR_W:0]     diff,
  input  logic signed [vpvc_pkg::SUM_W-1:0]   sum,
  output logic signed [vpvc_pkg::SUM_W-1:0]   corr
);
  import vpvc_pkg::*;

  localparam int PP_W  = GAIN_W + ERR_W;
  localparam int PD_W  = GAIN_W + ERR_W + 1;
  localparam int PI_W  = GAIN_W + SUM_W;
  localparam int ACC_W = PI_W + 1;

  logic signed [ERR_W-1:0]  err_d;
  logic signed [PP_W-1:0]   prod_p;
  logic signed [PD_W-1:0]   prod_d;
  logic signed [PI_W-1:0]   prod_i;

  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_shr;
  logic signed [WIDE_W-1:0] total;

  // multiplier stage
  always_ff @(posedge clk) begin
    if (adv) begin
      err_d  <= err;
      prod_p <= $signed(gains.prop) * err;
      prod_d <= $signed(gains.deriv) * diff;
      prod_i <= $signed(gains.integ) * sum;
    end
  end

  // arithmetic shift gives floor division by 256
  always_comb begin
    acc     = ACC_W'(prod_p) + ACC_W'(prod_d) + ACC_W'(prod_i);
    acc_shr = acc >>> 8;
    total   = WIDE_W'(acc_shr) + WIDE_W'(err_d);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      corr <= sat32(total);
    end
  end

endmodule

@@ rtl/vector_pid_velocity_corrector.sv @@
`timescale 1ns / 1ps
// A sample transaction passes the input, multiplier and result stages in turn before it reaches the result port.
// Throughput: one transaction per cycle; the input, multiplier and result stages advance
// together and hold while a finished result is stalled. Clears produce no result.
// Reset (synchronous, rst high): gains return to P=1.0, D=0, I=0; last errors,
// sums, sample count and all valid flags clear.
`include "vector_pid_velocity_corrector_defines.svh"
module vector_pid_velocity_corrector (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [vpvc_pkg::GAIN_W-1:0]       cfg_data,
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  logic                              command,
  input  logic signed [vpvc_pkg::ERR_W-1:0] err_x,
  input  logic signed [vpvc_pkg::ERR_W-1:0] err_y,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic signed [vpvc_pkg::SUM_W-1:0] out_x,
  output logic signed [vpvc_pkg::SUM_W-1:0] out_y
);
  import vpvc_pkg::*;

  gains_t gains;

  logic signed [ERR_W-1:0] last_err_x;
  logic signed [ERR_W-1:0] last_err_y;
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic [1:0]              sample_count;

  logic signed [SUM_W-1:0] sum_x_next;
  logic signed [SUM_W-1:0] sum_y_next;
  logic signed [ERR_W:0]   diff_x;
  logic signed [ERR_W:0]   diff_y;
  logic                    use_d;

  logic                    adv;
  logic                    accept;
  logic                    is_sample;

  logic                    s1_valid;
  logic                    s2_valid;
  logic signed [ERR_W-1:0] s1_err_x;
  logic signed [ERR_W-1:0] s1_err_y;
  logic signed [ERR_W:0]   s1_diff_x;
  logic signed [ERR_W:0]   s1_diff_y;
  logic signed [SUM_W-1:0] s1_sum_x;
  logic signed [SUM_W-1:0] s1_sum_y;

  assign cfg_ready    = 1'b1;
  assign adv          = !result_valid || !result_stall;
  assign sample_stall = !adv;
  assign accept       = sample_valid && adv;
  assign is_sample    = (cmd_t'(command) == CMD_SAMPLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      gains.prop  <= PROP_RESET;
      gains.deriv <= DERIV_RESET;
      gains.integ <= INTEG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_PROP:  gains.prop  <= cfg_data;
        CFG_DERIV: gains.deriv <= cfg_data;
        CFG_INTEG: gains.integ <= cfg_data;
        default: ;
      endcase
    end
  end

  // derivative only once a previous sample exists since the last clear
  always_comb begin
    use_d      = (sample_count != 2'd0);
    sum_x_next = sat32(WIDE_W'((SUM_W+1)'(sum_x) + (SUM_W+1)'(err_x)));
    sum_y_next = sat32(WIDE_W'((SUM_W+1)'(sum_y) + (SUM_W+1)'(err_y)));
    diff_x     = use_d ? ((ERR_W+1)'(err_x) - (ERR_W+1)'(last_err_x)) : '0;
    diff_y     = use_d ? ((ERR_W+1)'(err_y) - (ERR_W+1)'(last_err_y)) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_err_x   <= '0;
      last_err_y   <= '0;
      sum_x        <= '0;
      sum_y        <= '0;
      sample_count <= '0;
    end else if (accept) begin
      if (is_sample) begin
        last_err_x <= err_x;
        last_err_y <= err_y;
        sum_x      <= sum_x_next;
        sum_y      <= sum_y_next;
        if (sample_count != SAT_COUNT) begin
          sample_count <= sample_count + 2'd1;
        end
      end else begin
        sum_x        <= '0;
        sum_y        <= '0;
        sample_count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      s1_valid     <= accept && is_sample;
      s2_valid     <= s1_valid;
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_err_x  <= err_x;
      s1_err_y  <= err_y;
      s1_diff_x <= diff_x;
      s1_diff_y <= diff_y;
      s1_sum_x  <= sum_x_next;
      s1_sum_y  <= sum_y_next;
    end
  end

  vpvc_axis u_axis_x (
    .clk   (clk),
    .adv   (adv),
    .gains (gains),
    .err   (s1_err_x),
    .diff  (s1_diff_x),
    .sum   (s1_sum_x),
    .corr  (out_x)
  );

  vpvc_axis u_axis_y (
    .clk   (clk),
    .adv   (adv),
    .gains (gains),
    .err   (s1_err_y),
    .diff  (s1_diff_y),
    .sum   (s1_sum_y),
    .corr  (out_y)
  );

  `VPVC_ASSERT_ALWAYS(a_count_range, clk, rst, sample_count != 2'd3)
  `VPVC_ASSERT_NEXT(a_clear_zeroes, clk, rst, accept && !is_sample, (sum_x == '0) && (sum_y == '0) && (sample_count == 2'd0))
  `VPVC_ASSERT_NEXT(a_sum_nondecr, clk, rst, accept && is_sample && !err_x[ERR_W-1], sum_x >= $past(sum_x))
  `VPVC_ASSERT_NEXT(a_result_held, clk, rst, result_valid && result_stall, result_valid && $stable(out_x) && $stable(out_y))

endmodule

@@ bench/pid_correction_checker.sv @@
`timescale 1ns / 1ps
module pid_correction_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [vpvc_pkg::GAIN_W-1:0]        cfg_data,
  input  logic                               sample_valid,
  input  logic                               sample_stall,
  input  logic                               command,
  input  logic signed [vpvc_pkg::ERR_W-1:0]  err_x,
  input  logic signed [vpvc_pkg::ERR_W-1:0]  err_y,
  input  logic                               result_valid,
  input  logic                               result_stall,
  input  logic signed [vpvc_pkg::SUM_W-1:0]  out_x,
  input  logic signed [vpvc_pkg::SUM_W-1:0]  out_y,
  output int                                 pending,
  output int                                 fail_count
);
  import vpvc_pkg::*;

  localparam longint S32_TOP    = 64'sd2147483647;
  localparam longint S32_BOTTOM = -64'sd2147483648;
  localparam int     PRINT_CAP  = 50;

  typedef struct packed {
    logic signed [SUM_W-1:0] vx;
    logic signed [SUM_W-1:0] vy;
  } velocity_t;

  logic signed [GAIN_W-1:0] gain_p;
  logic signed [GAIN_W-1:0] gain_d;
  logic signed [GAIN_W-1:0] gain_i;
  logic signed [ERR_W-1:0]  last_x;
  logic signed [ERR_W-1:0]  last_y;
  logic signed [SUM_W-1:0]  total_x;
  logic signed [SUM_W-1:0]  total_y;
  logic [1:0]               seen;

  velocity_t expected_velocity[$];

  function automatic logic signed [SUM_W-1:0] clamp_s32(input longint v);
    if (v > S32_TOP) return S32_TOP[SUM_W-1:0];
    if (v < S32_BOTTOM) return S32_BOTTOM[SUM_W-1:0];
    return v[SUM_W-1:0];
  endfunction

  // arithmetic shift of the 64-bit mix gives the floor division by 256
  function automatic logic signed [SUM_W-1:0] corrected_axis(
    input logic signed [ERR_W-1:0] e,
    input logic signed [ERR_W-1:0] prev,
    input logic signed [SUM_W-1:0] total,
    input bit                      with_deriv
  );
    longint mix;
    mix = longint'(gain_p) * longint'(e) + longint'(gain_i) * longint'(total);
    if (with_deriv) mix += longint'(gain_d) * (longint'(e) - longint'(prev));
    return clamp_s32(longint'(e) + (mix >>> 8));
  endfunction

  task automatic report_mismatch(input string what);
    if (fail_count < PRINT_CAP) $display("%0t ns: mismatch: %s", $time, what);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    velocity_t want;
    logic signed [ERR_W-1:0] px;
    logic signed [ERR_W-1:0] py;
    if (rst) begin
      gain_p  = PROP_RESET;
      gain_d  = DERIV_RESET;
      gain_i  = INTEG_RESET;
      last_x  = '0;
      last_y  = '0;
      total_x = '0;
      total_y = '0;
      seen    = '0;
      expected_velocity.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PROP:  gain_p = cfg_data;
          CFG_DERIV: gain_d = cfg_data;
          CFG_INTEG: gain_i = cfg_data;
          default: ;
        endcase
      end

      if (result_valid && !result_stall) begin
        if (expected_velocity.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d, %0d", out_x, out_y));
        end else begin
          want = expected_velocity.pop_front();
          if (out_x !== want.vx)
            report_mismatch($sformatf("out_x got %0d want %0d", out_x, want.vx));
          if (out_y !== want.vy)
            report_mismatch($sformatf("out_y got %0d want %0d", out_y, want.vy));
        end
      end

      if (sample_valid && !sample_stall) begin
        if (command == CMD_CLEAR) begin
          // previous error is deliberately kept across a clear
          total_x = '0;
          total_y = '0;
          seen    = '0;
        end else begin
          px      = last_x;
          py      = last_y;
          last_x  = err_x;
          last_y  = err_y;
          total_x = clamp_s32(longint'(total_x) + longint'(err_x));
          total_y = clamp_s32(longint'(total_y) + longint'(err_y));
          if (seen < SAT_COUNT) seen++;
          want.vx = corrected_axis(err_x, px, total_x, seen == SAT_COUNT);
          want.vy = corrected_axis(err_y, py, total_y, seen == SAT_COUNT);
          expected_velocity.push_back(want);
        end
      end
    end
    pending <= expected_velocity.size();
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import vpvc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 6;
  localparam int PHASE_ITEMS = 90;
  localparam int SAT_ITEMS   = 60;

  localparam logic signed [ERR_W-1:0]  ERR_TOP     = 16'sh7fff;
  localparam logic signed [ERR_W-1:0]  ERR_BOTTOM  = 16'sh8000;
  localparam logic signed [GAIN_W-1:0] GAIN_TOP    = 16'sh7fff;
  localparam logic signed [GAIN_W-1:0] GAIN_BOTTOM = 16'sh8000;

  localparam logic [1:0] RX_NONE  = 2'd0;
  localparam logic [1:0] RX_LIGHT = 2'd1;
  localparam logic [1:0] RX_HEAVY = 2'd2;

  logic                     clk          = 1'b0;
  logic                     rst          = 1'b1;
  logic                     cfg_valid    = 1'b0;
  logic                     cfg_ready;
  logic [1:0]               cfg_index    = CFG_PROP;
  logic [GAIN_W-1:0]        cfg_data     = '0;
  logic                     sample_valid = 1'b0;
  logic                     sample_stall;
  logic                     command      = CMD_SAMPLE;
  logic signed [ERR_W-1:0]  err_x        = '0;
  logic signed [ERR_W-1:0]  err_y        = '0;
  logic                     result_valid;
  logic                     result_stall = 1'b0;
  logic signed [SUM_W-1:0]  out_x;
  logic signed [SUM_W-1:0]  out_y;

  logic [1:0] stall_mode = RX_LIGHT;
  int         stall_hold = 0;
  int         cycle_count = 0;
  int         pending;
  int         fail_count;

  always #5 clk = ~clk;

  vector_pid_velocity_corrector uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .sample_valid(sample_valid), .sample_stall(sample_stall),
    .command(command), .err_x(err_x), .err_y(err_y),
    .result_valid(result_valid), .result_stall(result_stall),
    .out_x(out_x), .out_y(out_y)
  );

  pid_correction_checker chk (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .sample_valid(sample_valid), .sample_stall(sample_stall),
    .command(command), .err_x(err_x), .err_y(err_y),
    .result_valid(result_valid), .result_stall(result_stall),
    .out_x(out_x), .out_y(out_y),
    .pending(pending), .fail_count(fail_count)
  );

  // result side back-pressure, independent of the sender
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_hold   <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      case (stall_mode)
        RX_NONE: begin
          result_stall <= 1'b0;
        end
        RX_LIGHT: begin
          result_stall <= ($urandom_range(0, 3) == 0);
          stall_hold   <= $urandom_range(0, 2);
        end
        default: begin
          result_stall <= ($urandom_range(0, 1) == 0);
          stall_hold   <= $urandom_range(0, 11);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic signed [ERR_W-1:0] pick_error();
    case ($urandom_range(0, 9))
      0:       return ERR_TOP;
      1:       return ERR_BOTTOM;
      2, 3, 4: return ERR_W'($urandom_range(0, 64) - 32);
      default: return ERR_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return GAIN_TOP;
      1:       return GAIN_BOTTOM;
      2:       return '0;
      3:       return 16'sd256;
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  // leaves valid high; the caller lowers it
  task automatic send_sample(input cmd_t cmd, input logic signed [ERR_W-1:0] ex,
                             input logic signed [ERR_W-1:0] ey);
    sample_valid <= 1'b1;
    command      <= cmd;
    err_x        <= ex;
    err_y        <= ey;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic signed [GAIN_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_gains(input logic signed [GAIN_W-1:0] p,
                           input logic signed [GAIN_W-1:0] d,
                           input logic signed [GAIN_W-1:0] i);
    write_reg(CFG_PROP, p);
    write_reg(CFG_DERIV, d);
    write_reg(CFG_INTEG, i);
    cfg_valid <= 1'b0;
  endtask

  // the first edge lets the tracker catch up with the last transaction
  task automatic wait_results(input int extra);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic run_phase(input int n_items, input bit sender_idles);
    int burst_left;
    int gap;
    int pause_at;
    burst_left = $urandom_range(1, 16);
    pause_at   = $urandom_range(20, 80);
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 11) == 0)
        send_sample(CMD_CLEAR, ERR_W'($urandom), ERR_W'($urandom));
      else
        send_sample(CMD_SAMPLE, pick_error(), pick_error());
      if (k == pause_at) begin
        sample_valid <= 1'b0;
        wait_results(0);
      end else if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 16);
        gap = sender_idles ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
          sample_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    sample_valid <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset gains
    send_sample(CMD_SAMPLE, 16'sd100, -16'sd100);
    send_sample(CMD_SAMPLE, -16'sd1, 16'sd1);
    send_sample(CMD_SAMPLE, 16'sd0, 16'sd0);
    sample_valid <= 1'b0;
    wait_results(SETTLE);

    // gain extremes: output clamps, derivative start-up, clear keeps last error
    set_gains(GAIN_BOTTOM, GAIN_TOP, GAIN_TOP);
    send_sample(CMD_CLEAR, 16'sd0, 16'sd0);
    send_sample(CMD_SAMPLE, 16'sd0, 16'sd0);
    send_sample(CMD_SAMPLE, ERR_TOP, ERR_BOTTOM);
    send_sample(CMD_SAMPLE, ERR_BOTTOM, ERR_TOP);
    send_sample(CMD_SAMPLE, -16'sd1, 16'sd1);
    send_sample(CMD_CLEAR, ERR_TOP, ERR_BOTTOM);
    send_sample(CMD_SAMPLE, 16'sd5, -16'sd5);
    send_sample(CMD_SAMPLE, -16'sd7, 16'sd7);
    send_sample(CMD_SAMPLE, 16'sd3, 16'sd3);
    send_sample(CMD_CLEAR, 16'sd0, 16'sd0);
    send_sample(CMD_CLEAR, 16'sd0, 16'sd0);
    send_sample(CMD_SAMPLE, ERR_TOP, ERR_TOP);
    send_sample(CMD_SAMPLE, ERR_BOTTOM, ERR_BOTTOM);
    sample_valid <= 1'b0;
    wait_results(SETTLE);

    // small negative mixes must round towards minus infinity
    set_gains(16'sd1, 16'sd0, 16'sd0);
    send_sample(CMD_CLEAR, 16'sd0, 16'sd0);
    send_sample(CMD_SAMPLE, -16'sd1, 16'sd1);
    send_sample(CMD_SAMPLE, -16'sd255, 16'sd255);
    send_sample(CMD_SAMPLE, -16'sd256, 16'sd256);
    send_sample(CMD_SAMPLE, -16'sd257, 16'sd257);
    sample_valid <= 1'b0;
    wait_results(SETTLE);

    set_gains(GAIN_TOP, GAIN_BOTTOM, GAIN_BOTTOM);
    send_sample(CMD_SAMPLE, ERR_TOP, ERR_BOTTOM);
    send_sample(CMD_SAMPLE, ERR_BOTTOM, ERR_TOP);
    send_sample(CMD_SAMPLE, 16'sd1, -16'sd1);
    sample_valid <= 1'b0;
    wait_results(SETTLE);

    // long run of extreme errors into the running sums at full rate
    stall_mode <= RX_NONE;
    set_gains(16'sd0, 16'sd0, 16'sd256);
    send_sample(CMD_CLEAR, 16'sd0, 16'sd0);
    for (int k = 0; k < SAT_ITEMS; k++) send_sample(CMD_SAMPLE, ERR_TOP, ERR_BOTTOM);
    for (int k = 0; k < 4; k++) send_sample(CMD_SAMPLE, ERR_BOTTOM, ERR_TOP);
    send_sample(CMD_CLEAR, 16'sd0, 16'sd0);
    sample_valid <= 1'b0;
    wait_results(SETTLE);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0, 4:    stall_mode <= RX_LIGHT;
        2:       stall_mode <= RX_NONE;
        default: stall_mode <= RX_HEAVY;
      endcase
      set_gains(pick_gain(), pick_gain(), pick_gain());
      run_phase(PHASE_ITEMS, ph != 2 && ph != 3);
      wait_results(SETTLE);
    end

    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
